// ===== rtl/rti_pkg.sv =====
// ============================================================================
// rti_pkg : shared types, codes and micro-program for the ray/triangle test
// Holds the sequencer state type, control and status bundles, and the
// multiply-accumulate program that builds the cross and dot products.
// ============================================================================
package rti_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int STEP_W      = 5;
  localparam int N_MAC_STEPS = 24;

  // input opcodes
  localparam logic OPC_LOAD = 1'b0;
  localparam logic OPC_RAY  = 1'b1;

  // configuration register indexes
  localparam logic CFG_DET_THRESHOLD = 1'b0;
  localparam logic CFG_MIN_DISTANCE  = 1'b1;

  // miss reasons
  localparam logic [2:0] RSN_HIT      = 3'd0;
  localparam logic [2:0] RSN_PARALLEL = 3'd1;
  localparam logic [2:0] RSN_U_OUT    = 3'd2;
  localparam logic [2:0] RSN_V_OUT    = 3'd3;
  localparam logic [2:0] RSN_BEHIND   = 3'd4;

  // operand codes
  localparam logic [4:0] OP_E1X = 5'd0;
  localparam logic [4:0] OP_E1Y = 5'd1;
  localparam logic [4:0] OP_E1Z = 5'd2;
  localparam logic [4:0] OP_E2X = 5'd3;
  localparam logic [4:0] OP_E2Y = 5'd4;
  localparam logic [4:0] OP_E2Z = 5'd5;
  localparam logic [4:0] OP_SX  = 5'd6;
  localparam logic [4:0] OP_SY  = 5'd7;
  localparam logic [4:0] OP_SZ  = 5'd8;
  localparam logic [4:0] OP_DX  = 5'd9;
  localparam logic [4:0] OP_DY  = 5'd10;
  localparam logic [4:0] OP_DZ  = 5'd11;
  localparam logic [4:0] OP_HX  = 5'd12;
  localparam logic [4:0] OP_HY  = 5'd13;
  localparam logic [4:0] OP_HZ  = 5'd14;
  localparam logic [4:0] OP_QX  = 5'd15;
  localparam logic [4:0] OP_QY  = 5'd16;
  localparam logic [4:0] OP_QZ  = 5'd17;

  // accumulator destinations
  localparam logic [3:0] DST_HX = 4'd0;
  localparam logic [3:0] DST_HY = 4'd1;
  localparam logic [3:0] DST_HZ = 4'd2;
  localparam logic [3:0] DST_QX = 4'd3;
  localparam logic [3:0] DST_QY = 4'd4;
  localparam logic [3:0] DST_QZ = 4'd5;
  localparam logic [3:0] DST_A  = 4'd6;
  localparam logic [3:0] DST_U  = 4'd7;
  localparam logic [3:0] DST_V  = 4'd8;
  localparam logic [3:0] DST_T  = 4'd9;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MLOAD,
    S_MRUN,
    S_FOLD,
    S_CDET,
    S_CU,
    S_VSUM,
    S_VCMP,
    S_DOVF,
    S_DRUN,
    S_TMIN,
    S_PLOAD,
    S_PRUN,
    S_FIN
  } state_t;

  typedef struct packed {
    state_t              state;
    logic [STEP_W-1:0]   step;
    logic                last_iter;
  } ctrl_t;

  typedef struct packed {
    logic alu_neg;
    logic a_zero;
    logic u_neg;
    logic v_neg;
    logic t_neg;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic [4:0] msel;
    logic [4:0] qsel;
    logic       neg;
    logic       first;
    logic       last;
    logic [3:0] dest;
  } mac_op_t;

  function automatic mac_op_t mk(input logic [4:0] m, input logic [4:0] q, input logic n,
                                 input logic f, input logic l, input logic [3:0] d);
    mac_op_t r;
    r.msel  = m;
    r.qsel  = q;
    r.neg   = n;
    r.first = f;
    r.last  = l;
    r.dest  = d;
    return r;
  endfunction

  // h = d x e2, q = s x e1, a = e1.h, U = s.h, V = d.q, T = e2.q
  function automatic mac_op_t mac_prog(input logic [STEP_W-1:0] idx);
    mac_op_t r;
    case (idx)
      5'd0:    r = mk(OP_DY, OP_E2Z, 1'b0, 1'b1, 1'b0, DST_HX);
      5'd1:    r = mk(OP_DZ, OP_E2Y, 1'b1, 1'b0, 1'b1, DST_HX);
      5'd2:    r = mk(OP_DZ, OP_E2X, 1'b0, 1'b1, 1'b0, DST_HY);
      5'd3:    r = mk(OP_DX, OP_E2Z, 1'b1, 1'b0, 1'b1, DST_HY);
      5'd4:    r = mk(OP_DX, OP_E2Y, 1'b0, 1'b1, 1'b0, DST_HZ);
      5'd5:    r = mk(OP_DY, OP_E2X, 1'b1, 1'b0, 1'b1, DST_HZ);
      5'd6:    r = mk(OP_SY, OP_E1Z, 1'b0, 1'b1, 1'b0, DST_QX);
      5'd7:    r = mk(OP_SZ, OP_E1Y, 1'b1, 1'b0, 1'b1, DST_QX);
      5'd8:    r = mk(OP_SZ, OP_E1X, 1'b0, 1'b1, 1'b0, DST_QY);
      5'd9:    r = mk(OP_SX, OP_E1Z, 1'b1, 1'b0, 1'b1, DST_QY);
      5'd10:   r = mk(OP_SX, OP_E1Y, 1'b0, 1'b1, 1'b0, DST_QZ);
      5'd11:   r = mk(OP_SY, OP_E1X, 1'b1, 1'b0, 1'b1, DST_QZ);
      5'd12:   r = mk(OP_HX, OP_E1X, 1'b0, 1'b1, 1'b0, DST_A);
      5'd13:   r = mk(OP_HY, OP_E1Y, 1'b0, 1'b0, 1'b0, DST_A);
      5'd14:   r = mk(OP_HZ, OP_E1Z, 1'b0, 1'b0, 1'b1, DST_A);
      5'd15:   r = mk(OP_HX, OP_SX,  1'b0, 1'b1, 1'b0, DST_U);
      5'd16:   r = mk(OP_HY, OP_SY,  1'b0, 1'b0, 1'b0, DST_U);
      5'd17:   r = mk(OP_HZ, OP_SZ,  1'b0, 1'b0, 1'b1, DST_U);
      5'd18:   r = mk(OP_QX, OP_DX,  1'b0, 1'b1, 1'b0, DST_V);
      5'd19:   r = mk(OP_QY, OP_DY,  1'b0, 1'b0, 1'b0, DST_V);
      5'd20:   r = mk(OP_QZ, OP_DZ,  1'b0, 1'b0, 1'b1, DST_V);
      5'd21:   r = mk(OP_QX, OP_E2X, 1'b0, 1'b1, 1'b0, DST_T);
      5'd22:   r = mk(OP_QY, OP_E2Y, 1'b0, 1'b0, 1'b0, DST_T);
      5'd23:   r = mk(OP_QZ, OP_E2Z, 1'b0, 1'b0, 1'b1, DST_T);
      default: r = mk(OP_E1X, OP_E1X, 1'b0, 1'b0, 1'b0, DST_HX);
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/rti_alu.sv =====
// ============================================================================
// rti_alu : shared wide adder/subtractor
// The shared arithmetic unit of the block: Booth steps, sign folding,
// comparisons and restoring division steps all go through it.
// ============================================================================
module rti_alu #(
  parameter int W = 148
) (
  input  logic [W-1:0] opa,
  input  logic [W-1:0] opb,
  input  logic         sub,
  output logic [W-1:0] sum,
  output logic         neg
);
  logic [W-1:0] b_eff;

  assign b_eff = sub ? ~opb : opb;
  assign sum   = opa + b_eff + W'(sub);
  assign neg   = sum[W-1];
endmodule

// ===== rtl/rti_seq.sv =====
// ============================================================================
// rti_seq : sequencer for the ray/triangle test
// Steps the shared unit through the product program, sign fold, bound
// checks, division and hit-point accumulation.
// ============================================================================
module rti_seq #(
  parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           ray_go,
  input  rti_pkg::stat_t stat,
  output rti_pkg::ctrl_t ctrl
);
  import rti_pkg::*;

  localparam int IW = $clog2(COORD_WIDTH + 1);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [IW-1:0]     iter_r, iter_nxt;
  logic              last_iter;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      iter_r  <= iter_nxt;
    end
  end

  always_comb begin
    case (state_r)
      S_MRUN, S_PRUN: last_iter = (iter_r == IW'(COORD_WIDTH));
      S_DRUN:         last_iter = (iter_r == IW'(COORD_WIDTH - 2));
      default:        last_iter = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    iter_nxt  = iter_r;
    case (state_r)
      S_IDLE: begin
        step_nxt = '0;
        if (ray_go) state_nxt = S_MLOAD;
      end
      S_MLOAD: begin
        iter_nxt  = '0;
        state_nxt = S_MRUN;
      end
      S_MRUN: begin
        iter_nxt = iter_r + IW'(1);
        if (last_iter) begin
          if (step_r == STEP_W'(N_MAC_STEPS - 1)) begin
            step_nxt  = '0;
            state_nxt = S_FOLD;
          end else begin
            step_nxt  = step_r + STEP_W'(1);
            state_nxt = S_MLOAD;
          end
        end
      end
      S_FOLD: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(3)) state_nxt = S_CDET;
      end
      S_CDET: state_nxt = (stat.a_zero || stat.alu_neg) ? S_FIN : S_CU;
      S_CU:   state_nxt = (stat.u_neg || stat.alu_neg) ? S_FIN : S_VSUM;
      S_VSUM: state_nxt = S_VCMP;
      S_VCMP: state_nxt = (stat.v_neg || stat.alu_neg || stat.t_neg) ? S_FIN : S_DOVF;
      S_DOVF: begin
        iter_nxt  = '0;
        state_nxt = stat.alu_neg ? S_DRUN : S_TMIN;
      end
      S_DRUN: begin
        iter_nxt = iter_r + IW'(1);
        if (last_iter) state_nxt = S_TMIN;
      end
      S_TMIN: begin
        step_nxt  = '0;
        state_nxt = stat.alu_neg ? S_PLOAD : S_FIN;
      end
      S_PLOAD: begin
        iter_nxt  = '0;
        state_nxt = S_PRUN;
      end
      S_PRUN: begin
        iter_nxt = iter_r + IW'(1);
        if (last_iter) begin
          if (step_r == STEP_W'(2)) begin
            state_nxt = S_FIN;
          end else begin
            step_nxt  = step_r + STEP_W'(1);
            state_nxt = S_PLOAD;
          end
        end
      end
      S_FIN: if (stat.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign ctrl.state     = state_r;
  assign ctrl.step      = step_r;
  assign ctrl.last_iter = last_iter;
endmodule

// ===== rtl/ray_triangle_intersection.sv =====
// ============================================================================
// ray_triangle_intersection : fixed-point ray/triangle intersection test
// Vertex loads fill a nine-word triangle store; each ray is tested with one
// shared wide adder used for Booth multiplies, compares and division.
// ============================================================================
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | opcode, vertex_sel, pos_x/y/z, dir_x/y/z
//  out     | out_valid / out_ready| hit, miss_reason, distance, point_x/y/z
//  cfg     | cfg_we               | cfg_index, cfg_wdata
//
//  A ray's run time on a hit is set by the radix-2 Booth multiply-accumulate on
//  the shared adder (27 products); misses end early. in_ready is high only
//  while the sequencer is idle. A finished result waits in the output
//  register; the next transaction may be taken then.
//  No clearing pass after reset; the triangle store holds no reset value.
module ray_triangle_intersection #(
  parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rti_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [1:0]                    in_vertex_sel,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_pos_z,
  input  logic signed [COORD_WIDTH-1:0] in_dir_x,
  input  logic signed [COORD_WIDTH-1:0] in_dir_y,
  input  logic signed [COORD_WIDTH-1:0] in_dir_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic [2:0]                    out_miss_reason,
  output logic [COORD_WIDTH-2:0]        out_distance,
  output logic signed [COORD_WIDTH-1:0] out_point_x,
  output logic signed [COORD_WIDTH-1:0] out_point_y,
  output logic signed [COORD_WIDTH-1:0] out_point_z,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [31:0]                   cfg_wdata
);
  import rti_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int SW = CW + 1;
  localparam int HW = 2 * CW + 2;
  localparam int WA = 4 * CW + FRAC_BITS + 4;
  localparam int TW = CW - 1;

  ctrl_t   ctrl;
  stat_t   stat;
  mac_op_t prog;

  logic signed [CW-1:0] store_r [9];
  logic signed [CW-1:0] o_r  [3];
  logic signed [SW-1:0] d_r  [3];
  logic signed [SW-1:0] e1_r [3];
  logic signed [SW-1:0] e2_r [3];
  logic signed [SW-1:0] s_r  [3];
  logic signed [HW-1:0] wide_r [6];
  logic signed [WA-1:0] dot_r [4];
  logic signed [WA-1:0] acc_r, acc_nxt;
  logic signed [WA-1:0] mop_r;
  logic signed [SW-1:0] qop_r;
  logic                 qprev_r;
  logic [WA-1:0]        div_r;
  logic [TW-1:0]        t_r;
  logic [2:0]           reason_r;
  logic signed [CW-1:0] point_r [3];
  logic [31:0]          det_threshold_r;
  logic [30:0]          min_distance_r;

  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [2:0]           out_reason_r;
  logic [TW-1:0]        out_distance_r;
  logic signed [CW-1:0] out_point_r [3];

  logic                 in_acc;
  logic [WA-1:0]        alu_a, alu_b, alu_sum;
  logic                 alu_sub, alu_neg;
  logic                 booth_act;
  logic signed [WA-1:0] m_val;
  logic signed [SW-1:0] q_val;
  logic [1:0]           fold_idx;
  logic [1:0]           pidx;
  logic [WA-1-(FRAC_BITS+CW-1):0] p_hi;
  logic signed [CW-1:0] p_sat;

  assign in_ready = (ctrl.state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign prog     = mac_prog(ctrl.step);
  assign fold_idx = 2'd3 - ctrl.step[1:0];
  assign pidx     = ctrl.step[1:0];
  assign booth_act = qop_r[0] ^ qprev_r;

  assign stat.alu_neg  = alu_neg;
  assign stat.a_zero   = ~|dot_r[0];
  assign stat.u_neg    = dot_r[1][WA-1];
  assign stat.v_neg    = dot_r[2][WA-1];
  assign stat.t_neg    = dot_r[3][WA-1];
  assign stat.out_free = !out_valid_r || out_ready;

  rti_seq #(.COORD_WIDTH(COORD_WIDTH)) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .ray_go (in_acc && (in_opcode == OPC_RAY)),
    .stat   (stat),
    .ctrl   (ctrl)
  );

  rti_alu #(.W(WA)) u_alu (
    .opa (alu_a),
    .opb (alu_b),
    .sub (alu_sub),
    .sum (alu_sum),
    .neg (alu_neg)
  );

  always_comb begin
    case (prog.msel)
      OP_E1X:  m_val = WA'(e1_r[0]);
      OP_E1Y:  m_val = WA'(e1_r[1]);
      OP_E1Z:  m_val = WA'(e1_r[2]);
      OP_E2X:  m_val = WA'(e2_r[0]);
      OP_E2Y:  m_val = WA'(e2_r[1]);
      OP_E2Z:  m_val = WA'(e2_r[2]);
      OP_SX:   m_val = WA'(s_r[0]);
      OP_SY:   m_val = WA'(s_r[1]);
      OP_SZ:   m_val = WA'(s_r[2]);
      OP_DX:   m_val = WA'(d_r[0]);
      OP_DY:   m_val = WA'(d_r[1]);
      OP_DZ:   m_val = WA'(d_r[2]);
      OP_HX:   m_val = WA'(wide_r[0]);
      OP_HY:   m_val = WA'(wide_r[1]);
      OP_HZ:   m_val = WA'(wide_r[2]);
      OP_QX:   m_val = WA'(wide_r[3]);
      OP_QY:   m_val = WA'(wide_r[4]);
      OP_QZ:   m_val = WA'(wide_r[5]);
      default: m_val = '0;
    endcase
  end

  always_comb begin
    case (prog.qsel)
      OP_E1X:  q_val = e1_r[0];
      OP_E1Y:  q_val = e1_r[1];
      OP_E1Z:  q_val = e1_r[2];
      OP_E2X:  q_val = e2_r[0];
      OP_E2Y:  q_val = e2_r[1];
      OP_E2Z:  q_val = e2_r[2];
      OP_SX:   q_val = s_r[0];
      OP_SY:   q_val = s_r[1];
      OP_SZ:   q_val = s_r[2];
      OP_DX:   q_val = d_r[0];
      OP_DY:   q_val = d_r[1];
      OP_DZ:   q_val = d_r[2];
      default: q_val = '0;
    endcase
  end

  // operand routing into the shared adder
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (ctrl.state)
      S_MRUN, S_PRUN: begin
        alu_a   = acc_r;
        alu_b   = mop_r;
        alu_sub = (qop_r[0] & ~qprev_r) ^ ((ctrl.state == S_MRUN) & prog.neg);
      end
      S_FOLD: begin
        alu_b   = dot_r[fold_idx];
        alu_sub = 1'b1;
      end
      S_CDET: begin
        alu_a   = dot_r[0];
        alu_b   = WA'(det_threshold_r);
        alu_sub = 1'b1;
      end
      S_CU: begin
        alu_a   = dot_r[0];
        alu_b   = dot_r[1];
        alu_sub = 1'b1;
      end
      S_VSUM: begin
        alu_a = dot_r[1];
        alu_b = dot_r[2];
      end
      S_VCMP: begin
        alu_a   = dot_r[0];
        alu_b   = acc_r;
        alu_sub = 1'b1;
      end
      S_DOVF: begin
        alu_a   = dot_r[3] <<< FRAC_BITS;
        alu_b   = dot_r[0] <<< (CW - 1);
        alu_sub = 1'b1;
      end
      S_DRUN: begin
        alu_a   = acc_r;
        alu_b   = div_r;
        alu_sub = 1'b1;
      end
      S_TMIN: begin
        alu_a   = WA'(min_distance_r);
        alu_b   = WA'(t_r);
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  assign acc_nxt = booth_act ? alu_sum : acc_r;

  // hit point: floor shift and saturation to the coordinate range
  assign p_hi = acc_nxt[WA-1:FRAC_BITS+CW-1];
  always_comb begin
    if ((&p_hi) || !(|p_hi)) p_sat = acc_nxt[FRAC_BITS+CW-1:FRAC_BITS];
    else if (acc_nxt[WA-1])  p_sat = {1'b1, {(CW-1){1'b0}}};
    else                     p_sat = {1'b0, {(CW-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_threshold_r <= 32'd1;
      min_distance_r  <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DET_THRESHOLD: det_threshold_r <= cfg_wdata;
          CFG_MIN_DISTANCE:  min_distance_r  <= cfg_wdata[30:0];
          default: ;
        endcase
      end
      if (ctrl.state == S_FIN && stat.out_free) out_valid_r <= 1'b1;
      else if (out_ready)                      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_opcode == OPC_LOAD) begin
      for (int k = 0; k < 3; k++) begin
        if (in_vertex_sel == 2'(k)) begin
          store_r[3*k]   <= in_pos_x;
          store_r[3*k+1] <= in_pos_y;
          store_r[3*k+2] <= in_pos_z;
        end
      end
    end
    if (in_acc && in_opcode == OPC_RAY) begin
      o_r[0] <= in_pos_x;
      o_r[1] <= in_pos_y;
      o_r[2] <= in_pos_z;
      d_r[0] <= SW'(in_dir_x);
      d_r[1] <= SW'(in_dir_y);
      d_r[2] <= SW'(in_dir_z);
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= SW'(store_r[3+i]) - SW'(store_r[i]);
        e2_r[i] <= SW'(store_r[6+i]) - SW'(store_r[i]);
      end
      s_r[0]   <= SW'(in_pos_x) - SW'(store_r[0]);
      s_r[1]   <= SW'(in_pos_y) - SW'(store_r[1]);
      s_r[2]   <= SW'(in_pos_z) - SW'(store_r[2]);
      reason_r <= RSN_HIT;
    end

    case (ctrl.state)
      S_MLOAD: begin
        mop_r   <= m_val;
        qop_r   <= q_val;
        qprev_r <= 1'b0;
        if (prog.first) acc_r <= '0;
      end
      S_MRUN, S_PRUN: begin
        acc_r   <= acc_nxt;
        mop_r   <= mop_r <<< 1;
        qop_r   <= qop_r >>> 1;
        qprev_r <= qop_r[0];
        if (ctrl.state == S_MRUN && ctrl.last_iter && prog.last) begin
          case (prog.dest)
            DST_HX:  wide_r[0] <= acc_nxt[HW-1:0];
            DST_HY:  wide_r[1] <= acc_nxt[HW-1:0];
            DST_HZ:  wide_r[2] <= acc_nxt[HW-1:0];
            DST_QX:  wide_r[3] <= acc_nxt[HW-1:0];
            DST_QY:  wide_r[4] <= acc_nxt[HW-1:0];
            DST_QZ:  wide_r[5] <= acc_nxt[HW-1:0];
            DST_A:   dot_r[0]  <= acc_nxt;
            DST_U:   dot_r[1]  <= acc_nxt;
            DST_V:   dot_r[2]  <= acc_nxt;
            DST_T:   dot_r[3]  <= acc_nxt;
            default: ;
          endcase
        end
        if (ctrl.state == S_PRUN && ctrl.last_iter) point_r[pidx] <= p_sat;
      end
      S_FOLD: begin
        if (dot_r[0][WA-1]) dot_r[fold_idx] <= alu_sum;
      end
      S_CDET: begin
        if (stat.a_zero || alu_neg) reason_r <= RSN_PARALLEL;
      end
      S_CU: begin
        if (stat.u_neg || alu_neg) reason_r <= RSN_U_OUT;
      end
      S_VSUM: acc_r <= alu_sum;
      S_VCMP: begin
        if (stat.v_neg || alu_neg) reason_r <= RSN_V_OUT;
        else if (stat.t_neg)       reason_r <= RSN_BEHIND;
      end
      S_DOVF: begin
        acc_r <= alu_a;
        div_r <= dot_r[0] <<< (CW - 2);
        t_r   <= alu_neg ? '0 : '1;
      end
      S_DRUN: begin
        if (!alu_neg) acc_r <= alu_sum;
        t_r   <= {t_r[TW-2:0], !alu_neg};
        div_r <= div_r >> 1;
      end
      S_TMIN: begin
        if (!alu_neg) reason_r <= RSN_BEHIND;
      end
      S_PLOAD: begin
        acc_r   <= WA'(o_r[pidx]) <<< FRAC_BITS;
        mop_r   <= WA'(t_r);
        qop_r   <= d_r[pidx];
        qprev_r <= 1'b0;
      end
      S_FIN: begin
        if (stat.out_free) begin
          out_hit_r      <= (reason_r == RSN_HIT);
          out_reason_r   <= reason_r;
          out_distance_r <= (reason_r == RSN_HIT) ? t_r : '0;
          for (int i = 0; i < 3; i++) begin
            out_point_r[i] <= (reason_r == RSN_HIT) ? point_r[i] : '0;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_miss_reason = out_reason_r;
  assign out_distance    = out_distance_r;
  assign out_point_x     = out_point_r[0];
  assign out_point_y     = out_point_r[1];
  assign out_point_z     = out_point_r[2];

`ifndef SYNTHESIS
  a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit == (out_miss_reason == RSN_HIT)))
    else $error("hit flag disagrees with miss reason");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_distance == '0 && out_point_x == '0 &&
                                 out_point_y == '0 && out_point_z == '0))
    else $error("miss transaction carries nonzero payload");

  a_hit_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (WA'(out_distance) > WA'(min_distance_r)))
    else $error("hit reported at or below minimum distance");

  a_det_folded: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.state == S_CDET) |-> !dot_r[0][WA-1])
    else $error("determinant negative after sign fold");

  a_rem_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.state == S_DRUN) |-> !acc_r[WA-1])
    else $error("division remainder went negative");
`endif
endmodule
